// ----- src/double_ended_queue_core_assert.svh -----
// assertion macros shared by the deque checker
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// next-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// ----- src/deq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CAPACITY   = 64;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W      = COUNT_W + 1;

    localparam int REQ_W   = 3;
    localparam int VALUE_W = 32;
    localparam int ECOUNT_W = 7;
    localparam int ERR_W   = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VALUE_W-1:0] push_value;
    } deq_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
        logic [ECOUNT_W-1:0] element_count;
        logic                is_empty;
        logic [ERR_W-1:0]    error_code;
    } deq_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic issue;
    } deq_cmd_t;

endpackage

`default_nettype wire

// ----- src/deq_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if
    import deq_pkg::*;
();
    logic     valid;
    logic     ready;
    deq_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/deq_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface deq_rsp_if
    import deq_pkg::*;
();
    logic     valid;
    logic     ready;
    deq_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/deq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ----- src/deq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output deq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready   = (state_reg == ST_IDLE);
    assign cmd.accept = in_valid && in_ready;
    // the read overwrites the memory output registers, so wait for the old result to leave
    assign cmd.issue  = (state_reg == ST_READ) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cmd.issue)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/deq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath
    import deq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  deq_cmd_t cmd,
    input  deq_req_t req,
    output deq_rsp_t rsp
);

    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [ERR_W-1:0]   err_reg;
    logic [COUNT_W-1:0] res_count_reg;
    logic [ERR_W-1:0]   res_err_reg;

    logic               is_push, is_pop, full, empty, do_op;
    logic [ERR_W-1:0]   err_next;
    logic [ADDR_W-1:0]  head_dec, head_inc, tail_slot, back_slot, wr_addr;
    logic [SUM_W-1:0]   tail_sum, back_sum;
    logic [DATA_WIDTH-1:0] wr_data, rd_front, rd_back;
    logic               res_empty;

    assign is_push = (req.req_type == REQ_PUSH_FRONT) || (req.req_type == REQ_PUSH_BACK);
    assign is_pop  = (req.req_type == REQ_POP_FRONT) || (req.req_type == REQ_POP_BACK);
    assign full    = (count_reg == COUNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb
    begin
        priority if (is_push && full)
        begin
            err_next = ERR_FULL;
        end
        else if (is_pop && empty)
        begin
            err_next = ERR_EMPTY;
        end
        else
        begin
            err_next = ERR_OK;
        end
    end

    assign do_op = cmd.accept && (err_next == ERR_OK);

    // ring index arithmetic, sums stay below twice the capacity
    assign head_dec  = (head_reg == '0) ? ADDR_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc  = (head_reg == ADDR_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_slot = (tail_sum >= SUM_W'(CAPACITY)) ? ADDR_W'(tail_sum - SUM_W'(CAPACITY))
                                                      : ADDR_W'(tail_sum);
    // only meaningful when the queue is not empty
    assign back_sum  = SUM_W'(head_reg) + SUM_W'(count_reg) - 1'b1;
    assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ? ADDR_W'(back_sum - SUM_W'(CAPACITY))
                                                      : ADDR_W'(back_sum);

    assign wr_addr = (req.req_type == REQ_PUSH_FRONT) ? head_dec : tail_slot;
    assign wr_data = DATA_WIDTH'(req.push_value);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (do_op)
        begin
            unique case (req.req_type)
                REQ_PUSH_FRONT:
                begin
                    head_next  = head_dec;
                    count_next = count_reg + 1'b1;
                end
                REQ_PUSH_BACK:
                begin
                    count_next = count_reg + 1'b1;
                end
                REQ_POP_FRONT:
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
                REQ_POP_BACK:
                begin
                    count_next = count_reg - 1'b1;
                end
                default:
                begin
                    // query and unused codes leave the state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            err_reg <= err_next;
        end
        if (cmd.issue)
        begin
            res_count_reg <= count_reg;
            res_err_reg   <= err_reg;
        end
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk       (clk),
        .wr_en     (do_op && is_push),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (cmd.issue),
        .rd_addr_a (head_reg),
        .rd_addr_b (back_slot),
        .rd_data_a (rd_front),
        .rd_data_b (rd_back)
    );

    assign res_empty         = (res_count_reg == '0);
    assign rsp.front_value   = res_empty ? '0 : VALUE_W'(rd_front);
    assign rsp.back_value    = res_empty ? '0 : VALUE_W'(rd_back);
    assign rsp.element_count = ECOUNT_W'(res_count_reg);
    assign rsp.is_empty      = res_empty;
    assign rsp.error_code    = res_err_reg;

endmodule

`default_nettype wire

// ----- src/double_ended_queue_core.sv -----
// channel  | dir | payload                                            | transfer
// req      | in  | req_type, push_value                               | valid & ready
// rsp      | out | front_value, back_value, element_count, is_empty,  | valid & ready
//          |     | error_code                                         |
//
// the accept edge writes the ring memory on a push and updates head and count; the issue
// edge in ST_READ reads front and back through the memory's two read ports.
// one request is in flight at a time; a new request is taken while a result waits.
// reset clears head, count and the handshake state; the memory needs no clearing.
// a stalled result holds the read: the request behind it waits in ST_READ until
// the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core
    import deq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    deq_cmd_t cmd;
    deq_rsp_t rsp_data;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    deq_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req.payload),
        .rsp   (rsp_data)
    );

    assign rsp.payload = rsp_data;

endmodule

`default_nettype wire

// ----- src/deq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_core_assert.svh"

module deq_checker
    import deq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input deq_rsp_t rsp_payload
);

    `DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
    `DEQ_ASSERT_NOW(a_empty_flag, rsp_valid, rsp_payload.is_empty == (rsp_payload.element_count == '0))
    `DEQ_ASSERT_NOW(a_empty_zero, rsp_valid && rsp_payload.is_empty, rsp_payload.front_value == '0 && rsp_payload.back_value == '0)
    `DEQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

endmodule

bind double_ended_queue_core deq_checker u_deq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

`default_nettype wire
